/* hw/rtl/ada_ss_pkg.sv */
// Types and character codes for the Ada statement splitter.
// No dependencies; used by ada_statement_splitter_core.
package ada_ss_pkg;

  // Source byte codes the splitter reacts to
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Reset value of the length limit register
  localparam logic [15:0] LIMIT_RESET = 16'd1024;

  // One input transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       statement_end;
  } out_item_t;

endpackage

/* hw/rtl/ada_statement_splitter_core.sv */
// Top level of the Ada statement splitter: comment stripping, statement
// splitting and a three-entry result queue.
// Depends on ada_ss_pkg.
// Results are registered in the result queue; out_item shows the queue head.
// Throughput: one input transaction per cycle while in_stall is low; a byte that
// yields two results raises in_stall until the result queue drains below two.
// in_stall is high while the result queue holds two or more results.
// Reset (synchronous, rst_n low): clears all flags, the byte count and the
// queue; the length limit returns to 1024.
module ada_statement_splitter_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ada_ss_pkg::in_item_t  in_item,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output ada_ss_pkg::out_item_t out_item,
  // configuration
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [16:0] THR_CAP = 17'((64'd1 << COUNT_WIDTH) - 64'd2);
  localparam int QDEPTH = 3;

  // statement state
  logic                   in_string_r, in_string_nxt;
  logic                   in_comment_r, in_comment_nxt;
  logic                   dash_r, dash_nxt;
  logic                   esc_r, esc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [15:0]            limit_r;

  // result queue, entry 0 is the head
  ada_ss_pkg::out_item_t  q_r [QDEPTH];
  ada_ss_pkg::out_item_t  q_nxt [QDEPTH];
  logic [1:0]             q_cnt_r, q_cnt_nxt;

  logic                   in_acc;
  logic                   pop;
  logic [1:0]             npush;
  logic                   item_end;
  ada_ss_pkg::out_item_t  res0, res1;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (q_cnt_r > 2'd1);
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_item  = q_r[0];
  assign pop       = out_valid && !out_stall;

  // Decode one byte into up to two results and the next statement state
  always_comb begin
    logic [7:0]             b;
    logic                   check;
    logic                   stmt_end;
    logic [COUNT_WIDTH:0]   cnt_sum;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic [15:0]            thr16;
    logic [16:0]            thr;

    b              = in_item.in_byte;
    check          = 1'b0;
    stmt_end       = 1'b0;
    npush          = 2'd0;
    res0           = '0;
    res1           = '0;
    in_string_nxt  = in_string_r;
    in_comment_nxt = in_comment_r;
    dash_nxt       = dash_r;
    esc_nxt        = esc_r;

    if (in_item.end_of_input) begin
      if (cnt_r != '0) begin
        res0.statement_end = 1'b1;
        npush              = 2'd1;
      end
    end else if (esc_r) begin
      esc_nxt  = 1'b0;
      res0     = '{out_byte: b, has_byte: 1'b1, statement_end: 1'b0};
      npush    = 2'd1;
      check    = 1'b1;
    end else if (dash_r) begin
      dash_nxt = 1'b0;
      if (b == ada_ss_pkg::CH_DASH) begin
        in_comment_nxt = 1'b1;
      end else begin
        res0  = '{out_byte: ada_ss_pkg::CH_DASH, has_byte: 1'b1, statement_end: 1'b0};
        res1  = '{out_byte: b, has_byte: 1'b1, statement_end: 1'b0};
        npush = 2'd2;
        check = 1'b1;
      end
    end else begin
      unique case (b)
        ada_ss_pkg::CH_QUOTE: begin
          in_string_nxt = !in_string_r;
          res0  = '{out_byte: b, has_byte: 1'b1, statement_end: 1'b0};
          npush = 2'd1;
          check = 1'b1;
        end
        ada_ss_pkg::CH_SEMICOLON: begin
          if (!in_comment_r) begin
            res0     = '{out_byte: b, has_byte: 1'b1, statement_end: 1'b0};
            npush    = 2'd1;
            stmt_end = 1'b1;
          end
        end
        ada_ss_pkg::CH_NEWLINE: begin
          in_comment_nxt = 1'b0;
        end
        ada_ss_pkg::CH_DASH: begin
          if (!in_comment_r && !in_string_r) begin
            dash_nxt = 1'b1;
          end
        end
        ada_ss_pkg::CH_BACKSLASH: begin
          res0  = '{out_byte: b, has_byte: 1'b1, statement_end: 1'b0};
          npush = 2'd1;
          if (in_string_r) begin
            esc_nxt = 1'b1;
          end else begin
            check = 1'b1;
          end
        end
        default: begin
          if (!in_comment_r) begin
            res0  = '{out_byte: b, has_byte: 1'b1, statement_end: 1'b0};
            npush = 2'd1;
            check = 1'b1;
          end
        end
      endcase
    end

    // Advance the saturating byte count (end markers carry no byte)
    if (in_item.end_of_input) begin
      cnt_sum = {1'b0, cnt_r};
    end else begin
      cnt_sum = {1'b0, cnt_r} + (COUNT_WIDTH+1)'(npush);
    end
    cnt_new = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[COUNT_WIDTH-1:0];

    // Length threshold: limit minus two, at least one, capped by the counter
    thr16 = (limit_r > 16'd2) ? (limit_r - 16'd2) : 16'd1;
    thr   = ({1'b0, thr16} > THR_CAP) ? THR_CAP : {1'b0, thr16};

    if (check && (npush != 2'd0) && (17'(cnt_new) >= thr)) begin
      stmt_end = 1'b1;
    end

    item_end = in_item.end_of_input || (stmt_end && (npush != 2'd0));
    if (stmt_end && (npush != 2'd0)) begin
      if (npush == 2'd2) begin
        res1.statement_end = 1'b1;
      end else begin
        res0.statement_end = 1'b1;
      end
    end

    // Clear the statement state once a statement ends
    if (item_end) begin
      in_string_nxt  = 1'b0;
      in_comment_nxt = 1'b0;
      dash_nxt       = 1'b0;
      esc_nxt        = 1'b0;
      cnt_nxt        = '0;
    end else begin
      cnt_nxt        = cnt_new;
    end
  end

  // Shift out the head on a pop, then append new results
  always_comb begin
    logic [1:0] base;

    base = q_cnt_r - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (in_acc && (npush != 2'd0) && (2'(i) == base)) begin
        q_nxt[i] = res0;
      end
      if (in_acc && (npush == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_nxt[i] = res1;
      end
    end
    q_cnt_nxt = base + (in_acc ? npush : 2'd0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r  <= 1'b0;
      in_comment_r <= 1'b0;
      dash_r       <= 1'b0;
      esc_r        <= 1'b0;
      cnt_r        <= '0;
      limit_r      <= ada_ss_pkg::LIMIT_RESET;
      q_cnt_r      <= 2'd0;
    end else begin
      if (in_acc) begin
        in_string_r  <= in_string_nxt;
        in_comment_r <= in_comment_nxt;
        dash_r       <= dash_nxt;
        esc_r        <= esc_nxt;
        cnt_r        <= cnt_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // A pending dash and a pending escape never coexist
  a_dash_esc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(dash_r && esc_r))
    else $error("dash and escape pending together");

  // An ended statement leaves a cleared count and flags
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && item_end) |=> (cnt_r == '0 && !in_string_r && !in_comment_r
                              && !dash_r && !esc_r))
    else $error("statement state not cleared after statement end");

  // A bare end marker always closes a statement
  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.has_byte) |-> out_item.statement_end)
    else $error("end marker without statement end");

  // Input is taken only while the queue has room for two results
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (q_cnt_r <= 2'd1))
    else $error("input accepted with a full result queue");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for ada_statement_splitter_core: splitting and comment stripping.
// Depends on ada_ss_pkg and the core RTL. Feeds directed and random Ada-like byte streams
// under several length limits and checks every result against a cycle-free model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W = 16;
  localparam int CNT_CAP = (1 << COUNT_W) - 2;
  localparam int CNT_MAX = (1 << COUNT_W) - 1;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  ada_ss_pkg::in_item_t  in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ada_ss_pkg::out_item_t out_item;
  logic                  cfg_we = 1'b0;
  logic [15:0]           cfg_wdata = '0;

  ada_statement_splitter_core #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Source bytes waiting for the driver, and splitter output still owed by the DUT
  ada_ss_pkg::in_item_t  src_q[$];
  ada_ss_pkg::out_item_t emitted_q[$];
  int        err_cnt = 0;
  int        fed = 0;
  logic      quiet = 1'b0;

  // Model state of the splitter
  logic [15:0] lim_m = ada_ss_pkg::LIMIT_RESET;
  logic        str_m, cmt_m, dash_m, esc_m;
  int          cnt_m;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Reset: hold low at start, then release for good
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Safety net against a hung DUT
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void clear_stmt();
    str_m  = 1'b0;
    cmt_m  = 1'b0;
    dash_m = 1'b0;
    esc_m  = 1'b0;
    cnt_m  = 0;
  endfunction

  // Queue one expected result; only real bytes advance the statement count
  function automatic void emit(logic [7:0] b, logic has);
    ada_ss_pkg::out_item_t r;
    r.out_byte      = has ? b : 8'h00;
    r.has_byte      = has;
    r.statement_end = 1'b0;
    emitted_q.push_back(r);
    if (has && cnt_m < CNT_MAX) cnt_m++;
  endfunction

  // Predict the results of one accepted source transaction
  function automatic void split_step(ada_ss_pkg::in_item_t it);
    int         n0;
    int         thr;
    logic       stop;
    logic       chk;
    logic [7:0] b;
    n0   = emitted_q.size();
    stop = 1'b0;
    chk  = 1'b0;
    b    = it.in_byte;
    if (it.end_of_input) begin
      // End of input: bare end marker only when the statement holds bytes
      if (cnt_m > 0) begin
        emit(8'h00, 1'b0);
        emitted_q[$].statement_end = 1'b1;
      end
      clear_stmt();
      return;
    end
    if (esc_m) begin
      // Escaped byte inside a string passes raw
      esc_m = 1'b0;
      emit(b, 1'b1);
      chk = 1'b1;
    end else if (dash_m) begin
      // Second dash opens a comment, anything else goes out raw behind the dash
      dash_m = 1'b0;
      if (b == ada_ss_pkg::CH_DASH) begin
        cmt_m = 1'b1;
      end else begin
        emit(ada_ss_pkg::CH_DASH, 1'b1);
        emit(b, 1'b1);
        chk = 1'b1;
      end
    end else begin
      case (b)
        ada_ss_pkg::CH_QUOTE: begin
          str_m = ~str_m;
          emit(b, 1'b1);
          chk = 1'b1;
        end
        ada_ss_pkg::CH_SEMICOLON: begin
          if (!cmt_m) begin
            emit(b, 1'b1);
            stop = 1'b1;
          end
        end
        ada_ss_pkg::CH_NEWLINE: cmt_m = 1'b0;
        ada_ss_pkg::CH_DASH: begin
          if (!cmt_m && !str_m) dash_m = 1'b1;
        end
        ada_ss_pkg::CH_BACKSLASH: begin
          emit(b, 1'b1);
          if (str_m) esc_m = 1'b1;
          else chk = 1'b1;
        end
        default: begin
          if (!cmt_m) begin
            emit(b, 1'b1);
            chk = 1'b1;
          end
        end
      endcase
    end
    // Length limit, never checked between a backslash and its escaped byte
    thr = (lim_m > 16'd2) ? int'(lim_m) - 2 : 1;
    if (thr > CNT_CAP) thr = CNT_CAP;
    if (chk && emitted_q.size() > n0 && cnt_m >= thr) stop = 1'b1;
    if (stop && emitted_q.size() > n0) begin
      emitted_q[$].statement_end = 1'b1;
      clear_stmt();
    end
  endfunction

  // Driver: present queued transactions, hold while stalled, idle in bursts
  int   drv_cyc = 0;
  int   gap_left = 0;
  logic drv_burst_on = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      gap_left = 0;
    end else begin
      drv_cyc++;
      if (drv_cyc % 128 == 0) drv_burst_on = $urandom_range(0, 2) != 0;
      if (!(in_valid && in_stall)) begin
        if (quiet) gap_left = 0;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!quiet && drv_burst_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 9) - 1;
          in_valid <= 1'b0;
        end else if (src_q.size() > 0) begin
          in_item  <= src_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: track the limit register, check results, predict accepted input, drive stall
  int   mon_cyc = 0;
  int   stall_left = 0;
  logic mon_burst_on = 1'b1;

  always @(posedge clk) begin
    ada_ss_pkg::out_item_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      lim_m = ada_ss_pkg::LIMIT_RESET;
      clear_stmt();
    end else begin
      if (cfg_we) lim_m = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (emitted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
          err_cnt++;
        end else begin
          exp_r = emitted_q.pop_front();
          if (out_item.out_byte !== exp_r.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     exp_r.out_byte, out_item.out_byte);
            err_cnt++;
          end
          if (out_item.has_byte !== exp_r.has_byte) begin
            $display("%0t: has_byte expected %b actual %b", $time,
                     exp_r.has_byte, out_item.has_byte);
            err_cnt++;
          end
          if (out_item.statement_end !== exp_r.statement_end) begin
            $display("%0t: statement_end expected %b actual %b", $time,
                     exp_r.statement_end, out_item.statement_end);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) split_step(in_item);
      mon_cyc++;
      if (mon_cyc % 128 == 0) mon_burst_on = $urandom_range(0, 2) != 0;
      if (quiet) stall_left = 0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && mon_burst_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus helpers
  function automatic void add_byte(logic [7:0] b);
    ada_ss_pkg::in_item_t it;
    it.in_byte      = b;
    it.end_of_input = 1'b0;
    src_q.push_back(it);
    fed++;
  endfunction

  function automatic void add_eoi();
    ada_ss_pkg::in_item_t it;
    it.in_byte      = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    src_q.push_back(it);
    fed++;
  endfunction

  function automatic logic [7:0] word_char();
    int k;
    k = $urandom_range(0, 37);
    if (k < 26) return 8'h61 + 8'(k);
    if (k < 36) return 8'h30 + 8'(k - 26);
    return 8'h20;
  endfunction

  // Byte found inside strings and comments
  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 9))
      0: return ada_ss_pkg::CH_DASH;
      1: return ada_ss_pkg::CH_SEMICOLON;
      2: return ada_ss_pkg::CH_QUOTE;
      3: return 8'($urandom_range(0, 255));
      default: return word_char();
    endcase
  endfunction

  // One token of Ada-like source, sometimes plain noise
  function automatic void add_token();
    int k;
    int len;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      len = $urandom_range(1, 6);
      repeat (len) add_byte(word_char());
    end else if (k < 48) begin
      // String literal with occasional escapes
      add_byte(ada_ss_pkg::CH_QUOTE);
      len = $urandom_range(0, 6);
      repeat (len) begin
        if ($urandom_range(0, 4) == 0) begin
          add_byte(ada_ss_pkg::CH_BACKSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          add_byte(body_char());
        end
      end
      add_byte(ada_ss_pkg::CH_QUOTE);
    end else if (k < 56) begin
      // Comment up to newline
      add_byte(ada_ss_pkg::CH_DASH);
      add_byte(ada_ss_pkg::CH_DASH);
      len = $urandom_range(0, 8);
      repeat (len) add_byte(body_char());
      add_byte(ada_ss_pkg::CH_NEWLINE);
    end else if (k < 63) begin
      add_byte(ada_ss_pkg::CH_DASH);
      add_byte(8'($urandom_range(0, 255)));
    end else if (k < 68) begin
      add_byte(ada_ss_pkg::CH_NEWLINE);
    end else if (k < 73) begin
      add_byte(ada_ss_pkg::CH_SEMICOLON);
    end else if (k < 78) begin
      add_byte(ada_ss_pkg::CH_BACKSLASH);
    end else if (k < 90) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (k < 95) begin
      add_eoi();
    end else begin
      add_byte(ada_ss_pkg::CH_QUOTE);
    end
  endfunction

  // Fill one phase with statements until the byte budget is reached
  function automatic void fill_statements(int budget);
    int ntok;
    int k;
    fed = 0;
    while (fed < budget) begin
      ntok = $urandom_range(1, 8);
      repeat (ntok) add_token();
      k = $urandom_range(0, 9);
      if (k < 8) add_byte(ada_ss_pkg::CH_SEMICOLON);
      else if (k == 8) add_eoi();
    end
  endfunction

  // Block until every transaction is accepted and every result is back
  task automatic wait_drained();
    @(negedge clk);
    while (src_q.size() > 0 || in_valid || emitted_q.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Sequencer: directed opening, then random phases across several limits
  initial begin
    logic [15:0] limits[5];
    int          budgets[5];
    limits  = '{16'd4, 16'd65535, 16'd7, 16'd0, 16'd10};
    budgets = '{250, 200, 250, 250, 120};
    wait (rst_n);
    @(negedge clk);

    // Directed: field extremes and each corner of the scanner, at the reset limit
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(ada_ss_pkg::CH_DASH);      // lone dash then ordinary byte
    add_byte(8'h78);
    add_byte(ada_ss_pkg::CH_DASH);      // byte after a lone dash is not interpreted
    add_byte(ada_ss_pkg::CH_SEMICOLON);
    add_byte(ada_ss_pkg::CH_DASH);
    add_byte(ada_ss_pkg::CH_NEWLINE);
    add_byte(ada_ss_pkg::CH_QUOTE);     // open string, drop dash, escape a quote
    add_byte(ada_ss_pkg::CH_DASH);
    add_byte(ada_ss_pkg::CH_BACKSLASH);
    add_byte(ada_ss_pkg::CH_QUOTE);
    add_byte(ada_ss_pkg::CH_QUOTE);
    add_byte(ada_ss_pkg::CH_DASH);      // comment: semicolon ignored, quote and backslash out
    add_byte(ada_ss_pkg::CH_DASH);
    add_byte(ada_ss_pkg::CH_SEMICOLON);
    add_byte(ada_ss_pkg::CH_QUOTE);
    add_byte(ada_ss_pkg::CH_BACKSLASH);
    add_byte(ada_ss_pkg::CH_NEWLINE);
    add_byte(ada_ss_pkg::CH_NEWLINE);
    add_byte(ada_ss_pkg::CH_SEMICOLON);
    add_eoi();              // nothing pending: no result
    add_byte(8'h61);
    add_eoi();              // bare end marker
    add_byte(ada_ss_pkg::CH_DASH);
    add_eoi();              // pending dash discarded
    fill_statements(280);
    wait_drained();

    // Random phases, each started from an idle DUT with a new limit
    for (int p = 0; p < 5; p++) begin
      if (limits[p] == 16'd0) limits[p] = 16'($urandom_range(4, 60));
      write_limit(limits[p]);
      if (p == 4) quiet = 1'b1;
      fill_statements(budgets[p]);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (err_cnt == 0 && emitted_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
